[sv/assert_macros.svh]
// Assertion macros used by the top level of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bsmm_pkg.sv]
// Shared constants, state encoding and command/status types for the batch statistics block.
`timescale 1ns / 1ps
`default_nettype none

package bsmm_pkg;

  localparam int MAX_BATCH   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 5;
  localparam int SUM_OUT_W   = 20;
  localparam int MEAN_OUT_W  = 24;
  localparam int MED_OUT_W   = 17;
  localparam int FRAC_BITS   = 8;

  localparam int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CNT_W     = $clog2(MAX_BATCH + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int MED_W     = SAMPLE_BITS + 1;
  localparam int DVD_W     = SUM_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MED_A,
    ST_MED_B,
    ST_MED_C,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_INS,
    RD_MED_LO,
    RD_MED_HI
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    shift;
    logic    place;
    logic    med_lo;
    logic    med_hi;
    logic    div_start;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic rdata_gt;
    logic last_item;
    logic div_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/bsmm_div.sv]
// Radix-2 restoring divider for the Q8 mean, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bsmm_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [bsmm_pkg::SUM_W-1:0]   dividend,
  input  wire logic        [bsmm_pkg::CNT_W-1:0]   divisor,
  output logic                                     busy,
  output logic signed      [bsmm_pkg::DVD_W-1:0]   quotient
);

  localparam int DVD_W     = bsmm_pkg::DVD_W;
  localparam int CNT_W     = bsmm_pkg::CNT_W;
  localparam int DIV_CNT_W = bsmm_pkg::DIV_CNT_W;
  localparam int FRAC_BITS = bsmm_pkg::FRAC_BITS;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     dq_r, dq_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;

  logic [DVD_W-1:0]     scaled;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;

  always_comb begin
    scaled = {dividend, {FRAC_BITS{1'b0}}};
    trial  = {rem_r, dq_r[DVD_W-1]};
    diff   = trial - {1'b0, dvs_r};
    ge     = (trial >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DVD_W);
      neg_nxt  = dividend[bsmm_pkg::SUM_W-1];
      // work on the magnitude, fix the sign at the end
      dq_nxt   = dividend[bsmm_pkg::SUM_W-1] ? (~scaled + DVD_W'(1)) : scaled;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = $signed(neg_r ? (~dq_r + DVD_W'(1)) : dq_r);

endmodule

`default_nettype wire

[sv/bsmm_dp.sv]
// Datapath: sorted sample store, running sum, median pick, mean divider and result registers.
`timescale 1ns / 1ps
`default_nettype none

module bsmm_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire bsmm_pkg::dp_cmd_t                        cmd,
  output bsmm_pkg::dp_sts_t                             sts,
  input  wire logic signed [bsmm_pkg::SAMPLE_BITS-1:0]  in_sample_value,
  input  wire logic                                     cfg_wr_en,
  input  wire logic        [bsmm_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic signed      [bsmm_pkg::SUM_OUT_W-1:0]    out_batch_sum,
  output logic signed      [bsmm_pkg::MEAN_OUT_W-1:0]   out_mean_q8,
  output logic signed      [bsmm_pkg::MED_OUT_W-1:0]    out_median_twice
);

  localparam int MAX_BATCH   = bsmm_pkg::MAX_BATCH;
  localparam int SAMPLE_BITS = bsmm_pkg::SAMPLE_BITS;
  localparam int IDX_W       = bsmm_pkg::IDX_W;
  localparam int CNT_W       = bsmm_pkg::CNT_W;
  localparam int SUM_W       = bsmm_pkg::SUM_W;
  localparam int MED_W       = bsmm_pkg::MED_W;
  localparam int DVD_W       = bsmm_pkg::DVD_W;
  localparam int CMP_W       = bsmm_pkg::CMP_W;
  localparam int CFG_W       = bsmm_pkg::CFG_W;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_BATCH];

  logic        [CFG_W-1:0]       bs_r;
  logic        [CNT_W-1:0]       fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic        [IDX_W-1:0]       pos_r, pos_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic signed [SAMPLE_BITS-1:0] med_a_r;
  logic signed [MED_W-1:0]       med2_r;

  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] lo_full, hi_full;
  logic [CMP_W-1:0] bs_ext, eff, fill_inc;

  logic                    div_busy;
  logic signed [DVD_W-1:0] quot;

  always_comb begin
    lo_full = (fill_r - CNT_W'(1)) >> 1;
    hi_full = fill_r >> 1;
    case (cmd.rd_sel)
      bsmm_pkg::RD_INS:    rd_addr = pos_r - IDX_W'(1);
      bsmm_pkg::RD_MED_LO: rd_addr = lo_full[IDX_W-1:0];
      bsmm_pkg::RD_MED_HI: rd_addr = hi_full[IDX_W-1:0];
      default:             rd_addr = pos_r - IDX_W'(1);
    endcase
  end

  // clamp the configured size to 1..MAX_BATCH
  always_comb begin
    bs_ext   = CMP_W'(bs_r);
    fill_inc = CMP_W'(fill_r) + CMP_W'(1);
    if (bs_ext == '0) begin
      eff = CMP_W'(1);
    end else if (bs_ext > CMP_W'(MAX_BATCH)) begin
      eff = CMP_W'(MAX_BATCH);
    end else begin
      eff = bs_ext;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cmd.accept) begin
      pos_nxt = fill_r[IDX_W-1:0];
    end else if (cmd.shift) begin
      pos_nxt = pos_r - IDX_W'(1);
    end
    if (cmd.place) begin
      fill_nxt = fill_r + CNT_W'(1);
      sum_nxt  = sum_r + SUM_W'(sample_r);
    end
    if (cmd.load_out) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r   <= bsmm_pkg::CFG_RESET;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        bs_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.accept) begin
      sample_r <= in_sample_value;
    end
    if (cmd.med_lo) begin
      med_a_r <= rdata_r;
    end
    if (cmd.med_hi) begin
      med2_r <= MED_W'(med_a_r) + MED_W'(rdata_r);
    end
    if (cmd.load_out) begin
      out_batch_sum    <= bsmm_pkg::SUM_OUT_W'(sum_r);
      out_mean_q8      <= bsmm_pkg::MEAN_OUT_W'(quot);
      out_median_twice <= bsmm_pkg::MED_OUT_W'(med2_r);
    end
  end

  // sorted store: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[pos_r] <= rdata_r;
    end else if (cmd.place) begin
      mem[pos_r] <= sample_r;
    end
    rdata_r <= mem[rd_addr];
  end

  bsmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    sts.pos_zero  = (pos_r == '0);
    sts.rdata_gt  = (rdata_r > sample_r);
    sts.last_item = (fill_inc >= eff);
    sts.div_busy  = div_busy;
  end

endmodule

`default_nettype wire

[sv/bsmm_ctrl.sv]
// Controller: sequences insertion, median reads, the divide and the result handoff.
`timescale 1ns / 1ps
`default_nettype none

module bsmm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire bsmm_pkg::dp_sts_t sts,
  output bsmm_pkg::dp_cmd_t      cmd
);

  bsmm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsmm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bsmm_pkg::ST_RD;
        end
      end
      bsmm_pkg::ST_RD: begin
        if (sts.pos_zero) begin
          state_nxt = sts.last_item ? bsmm_pkg::ST_MED_A : bsmm_pkg::ST_IDLE;
        end else begin
          state_nxt = bsmm_pkg::ST_CMP;
        end
      end
      bsmm_pkg::ST_CMP: begin
        if (sts.rdata_gt) begin
          state_nxt = bsmm_pkg::ST_RD;
        end else begin
          state_nxt = sts.last_item ? bsmm_pkg::ST_MED_A : bsmm_pkg::ST_IDLE;
        end
      end
      bsmm_pkg::ST_MED_A: state_nxt = bsmm_pkg::ST_MED_B;
      bsmm_pkg::ST_MED_B: state_nxt = bsmm_pkg::ST_MED_C;
      bsmm_pkg::ST_MED_C: state_nxt = bsmm_pkg::ST_DIV;
      bsmm_pkg::ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = bsmm_pkg::ST_OUT;
        end
      end
      bsmm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = bsmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = bsmm_pkg::RD_INS;
    case (state_r)
      bsmm_pkg::ST_IDLE:  cmd.accept = in_valid;
      bsmm_pkg::ST_RD:    cmd.place  = sts.pos_zero;
      bsmm_pkg::ST_CMP: begin
        // move the larger entry up one slot, or drop the sample into the gap
        cmd.shift = sts.rdata_gt;
        cmd.place = !sts.rdata_gt;
      end
      bsmm_pkg::ST_MED_A: begin
        cmd.rd_sel    = bsmm_pkg::RD_MED_LO;
        cmd.div_start = 1'b1;
      end
      bsmm_pkg::ST_MED_B: begin
        cmd.rd_sel = bsmm_pkg::RD_MED_HI;
        cmd.med_lo = 1'b1;
      end
      bsmm_pkg::ST_MED_C: cmd.med_hi   = 1'b1;
      bsmm_pkg::ST_OUT:   cmd.load_out = out_free;
      default:            cmd.rd_sel   = bsmm_pkg::RD_INS;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsmm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == bsmm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/batch_sum_mean_median_unit.sv]
// Top level of the batch sum, mean and median unit.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_sample_value (16b signed)
//   out_      output     out_valid/out_ready  out_batch_sum, out_mean_q8, out_median_twice
//   cfg_      input      cfg_wr_en            cfg_wr_data (batch size, 5b)
//
// A sample holds in_ready low while it walks down the store: one read-compare-move (ST_RD,
// ST_CMP) per stored entry greater than it (k of them, 0..15), then it is placed in the gap.
// For the last sample of a batch, the median reads and their sum (ST_MED_A..ST_MED_C) overlap
// the first two of the divider's 29 quotient-bit steps; then ST_OUT loads the result registers.
// Reset is synchronous, active low; batch size resets to 16. A result waiting on out_ready
// stalls only the load of the next batch result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module batch_sum_mean_median_unit (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [bsmm_pkg::SAMPLE_BITS-1:0]  in_sample_value,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed      [bsmm_pkg::SUM_OUT_W-1:0]    out_batch_sum,
  output logic signed      [bsmm_pkg::MEAN_OUT_W-1:0]   out_mean_q8,
  output logic signed      [bsmm_pkg::MED_OUT_W-1:0]    out_median_twice,
  input  wire logic                                     cfg_wr_en,
  input  wire logic        [bsmm_pkg::CFG_W-1:0]        cfg_wr_data
);

  bsmm_pkg::dp_cmd_t cmd;
  bsmm_pkg::dp_sts_t sts;

  bsmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsmm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_value  (in_sample_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_batch_sum    (out_batch_sum),
    .out_mean_q8      (out_mean_q8),
    .out_median_twice (out_median_twice)
  );

  `BSMM_ASSERT_IMP(a_no_req_while_div, clk, rst_n, sts.div_busy, !in_ready, "request taken during divide")
  `BSMM_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, (!out_valid || out_ready), "result overwritten")
  `BSMM_ASSERT_NXT(a_busy_after_req, clk, rst_n, (in_valid && in_ready), !in_ready, "ready after request")

endmodule

`default_nettype wire
